@@ src/kti_pkg.sv @@
// shared types and constants for the keyframe track interpolator
`timescale 1ns / 1ps

package kti_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int FRAME_W      = 16;
  localparam int VAL_W        = 32;
  localparam int CNT_IN_W     = 5;
  localparam int CFG_W        = 5;
  localparam int QUOT_W       = 17;
  localparam int DIV_STEPS    = 17;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_KEY_COUNT = 1'b0;
  localparam logic CFG_HOLD_MODE = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] z;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] x;
  } val_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    val_t               val;
  } key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HOLD,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_KEY0,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

@@ src/keyframe_track_interpolator_unit.sv @@
// keyframe track table with linear and hold lookup, one shared divide/multiply datapath
//
//   channel   dir   handshake              payload
//   in        in    in_valid / in_ready    req_type key_index frame in_x in_y in_z
//   out       out   out_valid / out_ready  answered out_x out_y out_z
//   cfg       in    cfg_write              cfg_index cfg_data
//
// a write beat or a query on an empty track goes straight to the output register,
// a hold query scans from the last key down
// a linear query runs a key scan through the one-port table,
// 17 restoring divide steps for t, then 3 multiply and add passes on one multiplier
// in_ready is high only in idle; one item is in flight at a time
// a finished result waits in the output register while the next beat is taken
// synchronous active-high reset clears control and configuration; the key table is not cleared
`timescale 1ns / 1ps

module keyframe_track_interpolator_unit #(
  parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [3:0]                          key_index,
  input  logic [kti_pkg::FRAME_W-1:0]         frame,
  input  logic signed [kti_pkg::VAL_W-1:0]    in_x,
  input  logic signed [kti_pkg::VAL_W-1:0]    in_y,
  input  logic signed [kti_pkg::VAL_W-1:0]    in_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                answered,
  output logic signed [kti_pkg::VAL_W-1:0]    out_x,
  output logic signed [kti_pkg::VAL_W-1:0]    out_y,
  output logic signed [kti_pkg::VAL_W-1:0]    out_z,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [kti_pkg::CFG_W-1:0]           cfg_data
);

  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);

  kti_pkg::state_t state, state_next;

  // configuration
  logic [kti_pkg::CNT_IN_W-1:0] key_count;
  logic                         hold_mode;

  // key table, one write and one registered read port
  kti_pkg::key_t key_mem [MAX_KEYS];
  kti_pkg::key_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W+3:0] kidx_ext;

  // sequencer and datapath registers
  logic [IDX_W-1:0]              idx;
  logic [kti_pkg::FRAME_W-1:0]   qf;
  kti_pkg::key_t                 prev;
  kti_pkg::val_t                 v1;
  logic [kti_pkg::FRAME_W-1:0]   dvs;
  logic [kti_pkg::QUOT_W-1:0]    rem;
  logic [kti_pkg::QUOT_W-1:0]    quot;
  logic [4:0]                    cnt;
  logic [1:0]                    comp;
  logic signed [50:0]            prod;
  kti_pkg::val_t                 res;
  logic                          res_ans;

  // decisions
  logic [CNT_W-1:0]            n;
  logic [IDX_W-1:0]            n_m1;
  logic                        in_fire;
  logic                        out_load;
  logic                        first_take;
  logic                        last_take;
  logic                        hold_take;
  logic                        seg_hit;
  logic                        seg_flat;
  logic                        scan_end;
  logic                        div_last;
  logic                        comp_last;
  logic [kti_pkg::QUOT_W-1:0]  trial;
  logic                        trial_ge;
  logic [kti_pkg::VAL_W-1:0]   sel_v0;
  logic [kti_pkg::VAL_W-1:0]   sel_v1;
  logic signed [32:0]          mul_d;
  logic [kti_pkg::VAL_W-1:0]   acc_sum;

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == kti_pkg::ST_DONE) && (!out_valid || out_ready);
  assign kidx_ext = (IDX_W + 4)'(key_index);

  always_comb begin
    if (32'(key_count) > 32'(MAX_KEYS)) begin
      n = CNT_W'(MAX_KEYS);
    end else begin
      n = CNT_W'(key_count);
    end
    n_m1 = IDX_W'(n - CNT_W'(1));
  end

  always_comb begin
    first_take = (n == CNT_W'(1)) || (qf <= rd_data.frame);
    last_take  = qf >= rd_data.frame;
    hold_take  = (qf >= rd_data.frame) || (idx == '0);
    seg_hit    = (prev.frame <= qf) && (qf <= rd_data.frame);
    seg_flat   = prev.frame == rd_data.frame;
    scan_end   = idx == n_m1;
    div_last   = cnt == 5'(kti_pkg::DIV_STEPS - 1);
    comp_last  = comp == 2'd2;
  end

  // shared restoring divide step: first step compares without a shift
  always_comb begin
    if (cnt == '0) begin
      trial = rem;
    end else begin
      trial = {rem[kti_pkg::QUOT_W-2:0], 1'b0};
    end
    trial_ge = trial >= {1'b0, dvs};
  end

  // component select for the shared multiplier and adder
  always_comb begin
    case (comp)
      2'd0: begin
        sel_v0 = prev.val.x;
        sel_v1 = v1.x;
      end
      2'd1: begin
        sel_v0 = prev.val.y;
        sel_v1 = v1.y;
      end
      default: begin
        sel_v0 = prev.val.z;
        sel_v1 = v1.z;
      end
    endcase
    mul_d   = $signed({sel_v1[kti_pkg::VAL_W-1], sel_v1})
            - $signed({sel_v0[kti_pkg::VAL_W-1], sel_v0});
    // low 32 bits of v0 + floor(prod / 65536)
    acc_sum = sel_v0 + prod[47:16];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kti_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (req_type == kti_pkg::REQ_WRITE || n == '0) begin
            state_next = kti_pkg::ST_DONE;
          end else if (hold_mode) begin
            state_next = kti_pkg::ST_HOLD;
          end else begin
            state_next = kti_pkg::ST_FIRST;
          end
        end
      end
      kti_pkg::ST_HOLD: begin
        if (hold_take) begin
          state_next = kti_pkg::ST_DONE;
        end
      end
      kti_pkg::ST_FIRST: begin
        state_next = first_take ? kti_pkg::ST_DONE : kti_pkg::ST_LAST;
      end
      kti_pkg::ST_LAST: begin
        state_next = last_take ? kti_pkg::ST_DONE : kti_pkg::ST_SCAN;
      end
      kti_pkg::ST_SCAN: begin
        if (seg_hit) begin
          state_next = seg_flat ? kti_pkg::ST_DONE : kti_pkg::ST_DIV;
        end else if (scan_end) begin
          state_next = kti_pkg::ST_KEY0;
        end
      end
      kti_pkg::ST_KEY0: state_next = kti_pkg::ST_DONE;
      kti_pkg::ST_DIV: begin
        if (div_last) begin
          state_next = kti_pkg::ST_MUL;
        end
      end
      kti_pkg::ST_MUL: state_next = kti_pkg::ST_ACC;
      kti_pkg::ST_ACC: begin
        if (comp_last) begin
          state_next = kti_pkg::ST_DONE;
        end else begin
          state_next = kti_pkg::ST_MUL;
        end
      end
      kti_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = kti_pkg::ST_IDLE;
        end
      end
      default: state_next = kti_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = '0;
    case (state)
      kti_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = hold_mode ? n_m1 : '0;
      end
      kti_pkg::ST_HOLD:  rd_addr = idx - IDX_W'(1);
      kti_pkg::ST_FIRST: rd_addr = n_m1;
      kti_pkg::ST_LAST:  rd_addr = IDX_W'(1);
      kti_pkg::ST_SCAN: begin
        // no segment holds the frame: fetch key 0 again
        rd_addr = (!seg_hit && scan_end) ? '0 : idx + IDX_W'(1);
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kti_pkg::ST_IDLE;
      key_count <= '0;
      hold_mode <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          kti_pkg::CFG_KEY_COUNT: key_count <= cfg_data;
          kti_pkg::CFG_HOLD_MODE: hold_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // key table
  always_ff @(posedge clk) begin
    if (in_fire && req_type == kti_pkg::REQ_WRITE && 32'(key_index) < 32'(MAX_KEYS)) begin
      key_mem[kidx_ext[IDX_W-1:0]] <= {frame, in_z, in_y, in_x};
    end
    rd_data <= key_mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      kti_pkg::ST_IDLE: begin
        qf      <= frame;
        idx     <= n_m1;
        res     <= '0;
        res_ans <= req_type;
      end
      kti_pkg::ST_HOLD: begin
        if (hold_take) begin
          res <= rd_data.val;
        end
        idx <= idx - IDX_W'(1);
      end
      kti_pkg::ST_FIRST: begin
        res  <= rd_data.val;
        prev <= rd_data;
      end
      kti_pkg::ST_LAST: begin
        res <= rd_data.val;
        idx <= IDX_W'(1);
      end
      kti_pkg::ST_SCAN: begin
        res  <= prev.val;
        dvs  <= rd_data.frame - prev.frame;
        rem  <= {1'b0, qf - prev.frame};
        quot <= '0;
        cnt  <= '0;
        comp <= '0;
        v1   <= rd_data.val;
        if (!seg_hit) begin
          prev <= rd_data;
          idx  <= idx + IDX_W'(1);
        end
      end
      kti_pkg::ST_KEY0: res <= rd_data.val;
      kti_pkg::ST_DIV: begin
        rem  <= trial_ge ? trial - {1'b0, dvs} : trial;
        quot <= {quot[kti_pkg::QUOT_W-2:0], trial_ge};
        cnt  <= cnt + 5'd1;
      end
      kti_pkg::ST_MUL: begin
        prod <= 51'($signed({1'b0, quot}) * mul_d);
      end
      kti_pkg::ST_ACC: begin
        case (comp)
          2'd0:    res.x <= acc_sum;
          2'd1:    res.y <= acc_sum;
          default: res.z <= acc_sum;
        endcase
        comp <= comp + 2'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      answered <= res_ans;
      out_x    <= res.x;
      out_y    <= res.y;
      out_z    <= res.z;
    end
  end

`ifndef SYNTHESIS
  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !answered |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("write acknowledge carries a non-zero value");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    state == kti_pkg::ST_MUL |-> quot <= 17'h10000)
    else $error("interpolation weight above one");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == kti_pkg::ST_DIV |-> dvs != '0)
    else $error("divide by a zero-length segment");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("beat taken while an item is in flight");
`endif

endmodule
